>>> sv/lcd_scanout_scroll_unpacker_unit_defines.svh
// Assertion macros used by the checker file of the scanout unit.
`ifndef LCD_SCANOUT_SCROLL_UNPACKER_UNIT_DEFINES_SVH
`define LCD_SCANOUT_SCROLL_UNPACKER_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define LSU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LSU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lcdsu_pkg.sv
package lcdsu_pkg;

    localparam int VRAM_BYTES_DEF = 8192;
    localparam int MAX_LINES_DEF  = 160;

    localparam logic [12:0] ADDR_WRAP    = 13'h1FE0;
    localparam logic [12:0] PITCH_NARROW = 13'h0030;
    localparam logic [12:0] PITCH_WIDE   = 13'h0060;
    localparam logic [7:0]  WIDE_LIMIT   = 8'hC3;
    localparam logic [13:0] LINE_STEP    = 14'h0030;
    localparam logic [5:0]  GROUPS_MAX   = 6'd40;

    localparam logic [1:0] REG_SCROLL_X = 2'd0;
    localparam logic [1:0] REG_SCROLL_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_X   = 2'd2;
    localparam logic [1:0] REG_SIZE_Y   = 2'd3;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [5:0] group_index;
        logic [7:0] line_index;
        logic       eol;
        logic       eof;
        logic       line_start;
        logic [1:0] fine;
    } meta_t;

    function automatic logic [7:0] grey_of(input logic [1:0] p);
        logic [7:0] g;
        case (p)
            2'd0:    g = 8'd255;
            2'd1:    g = 8'd170;
            2'd2:    g = 8'd85;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

    // Keep a line start address to 13 bits; the last-row value folds to zero.
    function automatic logic [12:0] wrap_start(input logic [13:0] a);
        logic [12:0] m;
        m = a[12:0];
        return (m == ADDR_WRAP) ? 13'd0 : m;
    endfunction

endpackage

>>> sv/lcdsu_vram.sv
module lcdsu_vram #(
    parameter int DEPTH = lcdsu_pkg::VRAM_BYTES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_a_reg;
    logic [7:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> sv/lcd_scanout_scroll_unpacker_unit.sv
// A tick item's bytes are registered at the video memory read ports, then its
// pixel group is unpacked into the result register. Throughput: one item per
// cycle unless out_stall holds the result; the two read ports fetch the carried
// byte and the new byte together at the start of a line. Reset is asynchronous
// and active low. After reset a clearing pass zeroes the video memory, one
// byte a cycle; no item is taken meanwhile, but configuration writes are.
module lcd_scanout_scroll_unpacker_unit #(
    parameter int VRAM_BYTES = lcdsu_pkg::VRAM_BYTES_DEF,
    parameter int MAX_LINES  = lcdsu_pkg::MAX_LINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [12:0] mem_address,
    input  logic [7:0]  mem_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  grey0,
    output logic [7:0]  grey1,
    output logic [7:0]  grey2,
    output logic [7:0]  grey3,
    output logic [5:0]  group_index,
    output logic [7:0]  line_index,
    output logic        end_of_line,
    output logic        end_of_frame
);

    localparam int AW = $clog2(VRAM_BYTES);
    localparam logic [AW-1:0] ADDR_LAST = AW'(VRAM_BYTES - 1);
    localparam logic [8:0] END_Y_MAX = 9'(MAX_LINES);

    // Reduce an address below 16K modulo the memory size (at least 1K).
    function automatic logic [AW-1:0] vram_mod(input logic [13:0] x);
        logic [19:0] r;
        r = 20'(x);
        for (int i = 3; i >= 0; i--)
        begin
            if (r >= (20'(VRAM_BYTES) << i))
            begin
                r = r - (20'(VRAM_BYTES) << i);
            end
        end
        return r[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == ADDR_LAST) ? '0 : a + 1'b1;
    endfunction

    // Configuration registers.
    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;
    logic [7:0] size_x_reg;
    logic [7:0] size_y_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg <= 8'd0;
            scroll_y_reg <= 8'd0;
            size_x_reg   <= 8'd160;
            size_y_reg   <= 8'd160;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                lcdsu_pkg::REG_SCROLL_X: scroll_x_reg <= pwdata[7:0];
                lcdsu_pkg::REG_SCROLL_Y: scroll_y_reg <= pwdata[7:0];
                lcdsu_pkg::REG_SIZE_X:   size_x_reg   <= pwdata[7:0];
                lcdsu_pkg::REG_SIZE_Y:   size_y_reg   <= pwdata[7:0];
                default:                 scroll_x_reg <= scroll_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            lcdsu_pkg::REG_SCROLL_X: prdata = 32'(scroll_x_reg);
            lcdsu_pkg::REG_SCROLL_Y: prdata = 32'(scroll_y_reg);
            lcdsu_pkg::REG_SIZE_X:   prdata = 32'(size_x_reg);
            lcdsu_pkg::REG_SIZE_Y:   prdata = 32'(size_y_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // Clearing pass after reset.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Handshake.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_move;
    logic in_fire;
    logic tick_go;
    logic wr_go;
    logic empty_frame;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clr_busy_reg || (s1_valid_reg && !s1_move);
    assign in_fire  = in_valid && !in_stall;
    assign wr_go    = in_fire && (kind == lcdsu_pkg::KIND_WRITE);
    assign tick_go  = in_fire && (kind == lcdsu_pkg::KIND_TICK) && !empty_frame;

    // Scan state and fetch addresses for the item being accepted.
    logic [12:0]   lsa_reg;
    logic [AW-1:0] fetch_reg;
    logic [5:0]    group_reg;
    logic [7:0]    line_reg;
    logic          active_reg;

    logic [8:0]    end_y;
    logic [5:0]    end_x;
    logic [12:0]   lsa_cur;
    logic [12:0]   pitch;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          eol;
    logic          eof;
    lcdsu_pkg::meta_t meta_in;

    always_comb
    begin
        end_y = (9'(size_y_reg) < END_Y_MAX) ? 9'(size_y_reg) : END_Y_MAX;
        end_x = (size_x_reg[7:2] > lcdsu_pkg::GROUPS_MAX) ? lcdsu_pkg::GROUPS_MAX
                                                          : size_x_reg[7:2];
        empty_frame = (end_y == 9'd0) || (end_x == 6'd0);

        // The vertical scroll is taken only as the first line of a frame starts.
        if (!active_reg && line_reg == 8'd0)
        begin
            lsa_cur = lcdsu_pkg::wrap_start(14'(scroll_y_reg) * lcdsu_pkg::LINE_STEP);
        end
        else
        begin
            lsa_cur = lsa_reg;
        end

        addr_a = vram_mod({1'b0, lsa_cur} + 14'(scroll_x_reg[7:2]));
        addr_b = active_reg ? fetch_reg : inc_wrap(addr_a);

        eol   = (7'(group_reg) + 7'd1) >= 7'(end_x);
        eof   = eol && ((9'(line_reg) + 9'd1) >= end_y);
        pitch = (size_x_reg > lcdsu_pkg::WIDE_LIMIT) ? lcdsu_pkg::PITCH_WIDE
                                                     : lcdsu_pkg::PITCH_NARROW;

        meta_in.group_index = group_reg;
        meta_in.line_index  = line_reg;
        meta_in.eol         = eol;
        meta_in.eof         = eof;
        meta_in.line_start  = !active_reg;
        meta_in.fine        = scroll_x_reg[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsa_reg    <= 13'd0;
            fetch_reg  <= '0;
            group_reg  <= 6'd0;
            line_reg   <= 8'd0;
            active_reg <= 1'b0;
        end
        else if (tick_go)
        begin
            fetch_reg  <= inc_wrap(addr_b);
            active_reg <= !eol;
            if (eol)
            begin
                group_reg <= 6'd0;
                lsa_reg   <= lcdsu_pkg::wrap_start({1'b0, lsa_cur} + {1'b0, pitch});
                line_reg  <= eof ? 8'd0 : line_reg + 8'd1;
            end
            else
            begin
                group_reg <= group_reg + 6'd1;
                lsa_reg   <= lsa_cur;
            end
        end
    end

    // Video memory: clearing pass or item writes, and the two tick reads.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rd_a;
    logic [7:0]    rd_b;

    assign mem_we    = clr_busy_reg || wr_go;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : vram_mod({1'b0, mem_address});
    assign mem_wdata = clr_busy_reg ? 8'd0 : mem_data;

    lcdsu_vram #(
        .DEPTH   (VRAM_BYTES)
    ) u_vram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (tick_go),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Stage one: read data is back; unpack the group.
    lcdsu_pkg::meta_t s1_meta_reg;
    logic [7:0]  carried_reg;
    logic [7:0]  carried_use;
    logic [15:0] pair;
    logic [7:0]  pix4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            carried_reg  <= 8'd0;
        end
        else
        begin
            if (tick_go)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                carried_reg <= rd_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            s1_meta_reg <= meta_in;
        end
    end

    always_comb
    begin
        carried_use = s1_meta_reg.line_start ? rd_a : carried_reg;
        pair        = {rd_b, carried_use};
        pix4        = 8'(pair >> {s1_meta_reg.fine, 1'b0});
    end

    // Result register.
    logic [7:0] grey0_reg;
    logic [7:0] grey1_reg;
    logic [7:0] grey2_reg;
    logic [7:0] grey3_reg;
    logic [5:0] group_index_reg;
    logic [7:0] line_index_reg;
    logic       eol_reg;
    logic       eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            grey0_reg       <= lcdsu_pkg::grey_of(pix4[1:0]);
            grey1_reg       <= lcdsu_pkg::grey_of(pix4[3:2]);
            grey2_reg       <= lcdsu_pkg::grey_of(pix4[5:4]);
            grey3_reg       <= lcdsu_pkg::grey_of(pix4[7:6]);
            group_index_reg <= s1_meta_reg.group_index;
            line_index_reg  <= s1_meta_reg.line_index;
            eol_reg         <= s1_meta_reg.eol;
            eof_reg         <= s1_meta_reg.eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign grey0        = grey0_reg;
    assign grey1        = grey1_reg;
    assign grey2        = grey2_reg;
    assign grey3        = grey3_reg;
    assign group_index  = group_index_reg;
    assign line_index   = line_index_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

>>> sv/lcdsu_checker.sv
`include "lcd_scanout_scroll_unpacker_unit_defines.svh"

module lcdsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] group_index,
    input logic       end_of_line,
    input logic       end_of_frame
);

    `LSU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `LSU_ASSERT(a_eof_is_eol, out_valid && end_of_frame |-> end_of_line, "frame end off a line end")
    `LSU_ASSERT(a_group_range, out_valid |-> group_index < lcdsu_pkg::GROUPS_MAX, "group out of range")
    `LSU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result shown in reset")
    `LSU_ASSERT_ALWAYS(a_clear_stall, rst_n && !$past(rst_n) |-> in_stall, "item taken while clearing")

endmodule

bind lcd_scanout_scroll_unpacker_unit lcdsu_checker u_lcdsu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .group_index  (group_index),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
);
